/* rtl/cap_pkg.sv */
package cap_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // sum clamps at reset, in whole units
  localparam int OUT_LIM_UNITS = 2000;
  localparam int IN_LIM_UNITS  = 500;

  localparam int CFG_ADDR_W = 5;

  // reciprocal constants for division by 1000 and by 5
  localparam int          DIV1000_DEN   = 1000;
  localparam logic [31:0] DIV1000_RECIP = 32'd4294967;
  localparam int          DIV1000_SHIFT = 32;
  localparam int          DIV5_DEN      = 5;
  localparam logic [31:0] DIV5_RECIP    = 32'd3435973836;
  localparam int          DIV5_SHIFT    = 34;

  localparam logic signed [34:0] ROUND_1000_OFS = 35'sd500;
  localparam logic signed [34:0] ROUND_5_OFS    = 35'sd2;

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

  typedef enum logic [2:0] {
    RI_OUTER_KP  = 3'd0,
    RI_OUTER_KI  = 3'd1,
    RI_OUTER_KD  = 3'd2,
    RI_INNER_KP  = 3'd3,
    RI_INNER_KI  = 3'd4,
    RI_INNER_KD  = 3'd5,
    RI_OUTER_LIM = 3'd6,
    RI_INNER_LIM = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MM_GAIN    = 2'd0,
    MM_DIV1000 = 2'd1,
    MM_DIV5    = 2'd2
  } mul_mode_t;

  typedef enum logic [3:0] {
    SP_OUT_P     = 4'd0,
    SP_OUT_SUM   = 4'd1,
    SP_OUT_I     = 4'd2,
    SP_OUT_BLEND = 4'd3,
    SP_OUT_D     = 4'd4,
    SP_IN_P      = 4'd5,
    SP_IN_SUM    = 4'd6,
    SP_IN_I      = 4'd7,
    SP_IN_D      = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ISSUE = 3'd1,
    ST_WAIT  = 3'd2,
    ST_FIX1  = 3'd3,
    ST_FIX2  = 3'd4,
    ST_FIN   = 3'd5
  } seq_state_t;

  typedef struct packed {
    logic [31:0] outer_kp;
    logic [31:0] outer_ki;
    logic [31:0] outer_kd;
    logic [31:0] inner_kp;
    logic [31:0] inner_ki;
    logic [31:0] inner_kd;
    logic [30:0] outer_lim;
    logic [30:0] inner_lim;
  } cfg_t;

  typedef struct packed {
    logic                start;
    mul_mode_t           mode;
    logic signed [34:0]  a;
    logic [31:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] drive;
    logic signed [31:0] rate_target;
  } seq_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [67:0] sx68(input logic signed [31:0] v);
    return {{36{v[31]}}, v};
  endfunction

endpackage

/* rtl/cap_regs.sv */
module cap_regs import cap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  localparam longint OUT_LIM_FULL = longint'(OUT_LIM_UNITS) << FRAC_BITS;
  localparam longint IN_LIM_FULL  = longint'(IN_LIM_UNITS) << FRAC_BITS;
  localparam logic [30:0] OUT_LIM_RST =
    (OUT_LIM_FULL > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : OUT_LIM_FULL[30:0];
  localparam logic [30:0] IN_LIM_RST =
    (IN_LIM_FULL > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : IN_LIM_FULL[30:0];

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_kp  <= '0;
      cfg_r.outer_ki  <= '0;
      cfg_r.outer_kd  <= '0;
      cfg_r.inner_kp  <= '0;
      cfg_r.inner_ki  <= '0;
      cfg_r.inner_kd  <= '0;
      cfg_r.outer_lim <= OUT_LIM_RST;
      cfg_r.inner_lim <= IN_LIM_RST;
    end else if (wr_en) begin
      case (idx)
        RI_OUTER_KP:  cfg_r.outer_kp  <= cfg_pwdata;
        RI_OUTER_KI:  cfg_r.outer_ki  <= cfg_pwdata;
        RI_OUTER_KD:  cfg_r.outer_kd  <= cfg_pwdata;
        RI_INNER_KP:  cfg_r.inner_kp  <= cfg_pwdata;
        RI_INNER_KI:  cfg_r.inner_ki  <= cfg_pwdata;
        RI_INNER_KD:  cfg_r.inner_kd  <= cfg_pwdata;
        RI_OUTER_LIM: cfg_r.outer_lim <= cfg_pwdata[30:0];
        RI_INNER_LIM: cfg_r.inner_lim <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RI_OUTER_KP:  cfg_prdata = cfg_r.outer_kp;
      RI_OUTER_KI:  cfg_prdata = cfg_r.outer_ki;
      RI_OUTER_KD:  cfg_prdata = cfg_r.outer_kd;
      RI_INNER_KP:  cfg_prdata = cfg_r.inner_kp;
      RI_INNER_KI:  cfg_prdata = cfg_r.inner_ki;
      RI_INNER_KD:  cfg_prdata = cfg_r.inner_kd;
      RI_OUTER_LIM: cfg_prdata = {1'b0, cfg_r.outer_lim};
      RI_INNER_LIM: cfg_prdata = {1'b0, cfg_r.inner_lim};
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

/* rtl/cap_mul.sv */
module cap_mul import cap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic signed [67:0] RND_HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic               v1_r, v2_r, v3_r, done_r;
  mul_mode_t          mode1_r, mode2_r, mode3_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [33:0]        mag1_r, mag2_r;
  logic [31:0]        b1_r;
  logic [65:0]        prod_r;
  logic signed [67:0] rnd_r;
  logic [31:0]        quo_r;
  logic [35:0]        rem_r;
  logic signed [31:0] res_r;

  logic [34:0]        a_neg;
  logic [33:0]        mag_nxt;
  logic [31:0]        b_nxt;
  logic signed [67:0] p68, rnd_nxt;
  logic [31:0]        quo_nxt;
  logic [35:0]        qd, rem_nxt;
  logic signed [67:0] rnd_sh;
  logic [35:0]        den;
  logic               bump, rem_nz;
  logic [32:0]        quo_fix, quo_neg;
  logic signed [31:0] res_nxt;

  // stage 1: magnitude and multiplicand select
  always_comb begin
    a_neg   = -req.a;
    mag_nxt = req.a[34] ? a_neg[33:0] : req.a[33:0];
    case (req.mode)
      MM_GAIN:    b_nxt = req.b;
      MM_DIV1000: b_nxt = DIV1000_RECIP;
      MM_DIV5:    b_nxt = DIV5_RECIP;
      default:    b_nxt = '0;
    endcase
  end

  // stage 3: rounding offset, or trial quotient and remainder
  always_comb begin
    p68     = {2'b00, prod_r};
    rnd_nxt = (neg2_r ? -p68 : p68) + RND_HALF;
    if (mode2_r == MM_DIV5) begin
      quo_nxt = prod_r[DIV5_SHIFT +: 32];
      qd      = (36'(quo_nxt) << 2) + 36'(quo_nxt);
    end else begin
      quo_nxt = prod_r[DIV1000_SHIFT +: 32];
      qd      = (36'(quo_nxt) << 10) - (36'(quo_nxt) << 4) - (36'(quo_nxt) << 3);
    end
    rem_nxt = {2'b00, mag2_r} - qd;
  end

  // stage 4: scale and saturate, or fix quotient and apply floor sign
  always_comb begin
    rnd_sh  = rnd_r >>> FRAC_BITS;
    den     = (mode3_r == MM_DIV5) ? 36'(DIV5_DEN) : 36'(DIV1000_DEN);
    bump    = (rem_r >= den);
    quo_fix = {1'b0, quo_r} + {32'd0, bump};
    rem_nz  = (rem_r != '0) && (rem_r != den);
    quo_neg = -(quo_fix + {32'd0, rem_nz});
    case (mode3_r)
      MM_GAIN:    res_nxt = sat32(rnd_sh);
      MM_DIV1000: res_nxt = neg3_r ? quo_neg[31:0] : quo_fix[31:0];
      MM_DIV5:    res_nxt = neg3_r ? quo_neg[31:0] : quo_fix[31:0];
      default:    res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= req.mode;
    neg1_r  <= req.a[34];
    mag1_r  <= mag_nxt;
    b1_r    <= b_nxt;
    mode2_r <= mode1_r;
    neg2_r  <= neg1_r;
    mag2_r  <= mag1_r;
    prod_r  <= 66'(mag1_r) * 66'(b1_r);
    mode3_r <= mode2_r;
    neg3_r  <= neg2_r;
    rnd_r   <= rnd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

/* rtl/cap_seq.sv */
module cap_seq import cap_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic signed [31:0] in_target,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_rate,
  input  logic               in_clear,
  input  logic               out_free,
  input  cfg_t               cfg,
  output logic               idle,
  output seq_res_t           res,
  output mul_req_t           mul_req,
  input  mul_rsp_t           mul_rsp
);

  seq_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  mul_req_t   mul_req_r, mul_req_nxt;

  logic signed [31:0] osum_r, ods_r, isum_r, last_rate_r, ids_r;
  logic signed [31:0] err_o_r, nd_o_r, nd_i_r, rate_r, err_i_r, rate_tgt_r;
  logic signed [33:0] acc_r;

  logic signed [67:0] rate_diff, diff_k;
  logic signed [33:0] res34;
  logic signed [32:0] ids_sum;

  function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] s,
                                                   input logic signed [31:0] q,
                                                   input logic [30:0]        lim);
    logic signed [33:0] v, lp, ln;
    logic signed [31:0] r;
    v  = {{2{s[31]}}, s} + {{2{q[31]}}, q};
    lp = {3'b000, lim};
    ln = -lp;
    if (v > lp) begin
      r = lp[31:0];
    end else if (v < ln) begin
      r = ln[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_ISSUE;
          step_nxt  = SP_OUT_P;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_rsp.done) begin
          if (step_r == SP_OUT_D) begin
            state_nxt = ST_FIX1;
          end else if (step_r == SP_IN_D) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ISSUE;
            step_nxt  = step_t'(step_r + 4'd1);
          end
        end
      end
      ST_FIX1: state_nxt = ST_FIX2;
      ST_FIX2: begin
        state_nxt = ST_ISSUE;
        step_nxt  = SP_IN_P;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle            = (state_r == ST_IDLE);
    res.valid       = (state_r == ST_FIN) && out_free;
    res.drive       = sat32({{34{acc_r[33]}}, acc_r});
    res.rate_target = rate_tgt_r;
    mul_req_nxt.start = (state_r == ST_ISSUE);
    case (step_r)
      SP_OUT_P: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{err_o_r[31]}}, err_o_r};
        mul_req_nxt.b    = cfg.outer_kp;
      end
      SP_OUT_SUM: begin
        mul_req_nxt.mode = MM_DIV1000;
        mul_req_nxt.a    = {{3{err_o_r[31]}}, err_o_r} + ROUND_1000_OFS;
        mul_req_nxt.b    = '0;
      end
      SP_OUT_I: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{osum_r[31]}}, osum_r};
        mul_req_nxt.b    = cfg.outer_ki;
      end
      SP_OUT_BLEND: begin
        mul_req_nxt.mode = MM_DIV5;
        mul_req_nxt.a    = {{2{ods_r[31]}}, ods_r, 1'b0} + {{3{nd_o_r[31]}}, nd_o_r}
                           + {{2{nd_o_r[31]}}, nd_o_r, 1'b0} + ROUND_5_OFS;
        mul_req_nxt.b    = '0;
      end
      SP_OUT_D: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{ods_r[31]}}, ods_r};
        mul_req_nxt.b    = cfg.outer_kd;
      end
      SP_IN_P: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{err_i_r[31]}}, err_i_r};
        mul_req_nxt.b    = cfg.inner_kp;
      end
      SP_IN_SUM: begin
        mul_req_nxt.mode = MM_DIV1000;
        mul_req_nxt.a    = {{3{err_i_r[31]}}, err_i_r} + ROUND_1000_OFS;
        mul_req_nxt.b    = '0;
      end
      SP_IN_I: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{isum_r[31]}}, isum_r};
        mul_req_nxt.b    = cfg.inner_ki;
      end
      SP_IN_D: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = {{3{ids_r[31]}}, ids_r};
        mul_req_nxt.b    = cfg.inner_kd;
      end
      default: begin
        mul_req_nxt.mode = MM_GAIN;
        mul_req_nxt.a    = '0;
        mul_req_nxt.b    = '0;
      end
    endcase
  end

  assign mul_req = mul_req_r;

  // rate difference times 1000 as shifts and subtractions
  assign rate_diff = sx68(last_rate_r) - sx68(in_rate);
  assign diff_k    = (rate_diff <<< 10) - (rate_diff <<< 4) - (rate_diff <<< 3);
  assign res34     = {{2{mul_rsp.res[31]}}, mul_rsp.res};
  assign ids_sum   = {ids_r[31], ids_r} + {nd_i_r[31], nd_i_r} + 33'sd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_OUT_P;
      mul_req_r   <= '0;
      osum_r      <= '0;
      ods_r       <= '0;
      isum_r      <= '0;
      last_rate_r <= '0;
      ids_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      mul_req_r <= mul_req_nxt;
      if (state_r == ST_IDLE && in_fire) begin
        last_rate_r <= in_rate;
        if (in_clear) begin
          osum_r <= '0;
          isum_r <= '0;
        end
      end
      if (state_r == ST_WAIT && mul_rsp.done) begin
        case (step_r)
          SP_OUT_SUM:   osum_r <= clamp_sum(osum_r, mul_rsp.res, cfg.outer_lim);
          SP_OUT_BLEND: ods_r  <= mul_rsp.res;
          SP_IN_SUM:    isum_r <= clamp_sum(isum_r, mul_rsp.res, cfg.inner_lim);
          default: ;
        endcase
      end
      if (state_r == ST_FIX1) begin
        ids_r <= ids_sum[32:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      err_o_r <= sat32(sx68(in_target) - sx68(in_angle));
      nd_o_r  <= sat32(-sx68(in_rate));
      nd_i_r  <= sat32(diff_k);
      rate_r  <= in_rate;
    end
    if (state_r == ST_WAIT && mul_rsp.done) begin
      case (step_r)
        SP_OUT_P: acc_r <= res34;
        SP_IN_P:  acc_r <= res34;
        SP_OUT_I: acc_r <= acc_r + res34;
        SP_OUT_D: acc_r <= acc_r + res34;
        SP_IN_I:  acc_r <= acc_r + res34;
        SP_IN_D:  acc_r <= acc_r + res34;
        default: ;
      endcase
    end
    if (state_r == ST_FIX1) begin
      rate_tgt_r <= sat32({{34{acc_r[33]}}, acc_r});
    end
    if (state_r == ST_FIX2) begin
      err_i_r <= sat32(sx68(rate_tgt_r) - sx68(rate_r));
    end
  end

endmodule

/* rtl/cascade_angle_rate_pid.sv */
// channel  | dir | handshake             | payload
// in_      | in  | tvalid/tready         | tdata: target, angle, rate; tuser: clear_sums
// out_     | out | tvalid/tready         | tdata: drive, rate_target
// cfg_     | in  | psel/penable/pwrite   | 8 registers at byte address 4*i
//
// an item makes nine serial passes through the shared 34x32 multiplier between
// the in transfer and out valid; a new item is taken only once the last result
// has moved into the out register, so a stalled out side holds the input
// a result waits in the out register while the next item is already worked on
// rst_n clears all loop state; sum limits come up at 2000 and 500
module cascade_angle_rate_pid import cap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,   // target_angle, measured_angle, measured_rate
  input  logic                  in_tuser,   // clear_sums
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // drive, rate_target
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  seq_res_t seq_res;
  logic     in_fire, out_free, seq_idle;
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  cap_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cap_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  cap_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_target (in_tdata[31:0]),
    .in_angle  (in_tdata[63:32]),
    .in_rate   (in_tdata[95:64]),
    .in_clear  (in_tuser),
    .out_free  (out_free),
    .cfg       (cfg),
    .idle      (seq_idle),
    .res       (seq_res),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

  assign in_tready  = seq_idle;
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (seq_res.valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res.valid) begin
      out_tdata_r <= {seq_res.rate_target, seq_res.drive};
    end
  end

  // busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while item in progress");

  // a new result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_res.valid |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten");

  // the shared unit only answers while an item is in work
  a_mul_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> !in_tready)
    else $error("multiplier result while idle");

endmodule
